// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted priority queue: field widths, codes and shared types.
// Used by every module of the block; depends on nothing else.

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRI_W = 16;
	localparam int VAL_W = 32;
	localparam int ST_W = 2;
	localparam int OCC_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic insert;
		logic remove;
	} spq_ctrl_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of spq_cell slots, the entry
// count and the registered result word. Depends on spq_pkg and spq_cell.
//
//   channel | signals                              | direction
//   input   | in_valid, in_ready, opcode,          | in
//           | entry_priority, entry_value          |
//   output  | out_valid, out_ready, status,        | out
//           | removed_value, removed_priority,     |
//           | occupancy                            |
//
// For each accepted word every cell compares and shifts in parallel, and the
// result word appears in the output register next cycle.
// A new word is taken whenever the output register is empty or being drained,
// so one word per cycle is sustained; a stalled output holds the input.
// Reset empties the queue at once; slot contents need no clearing.

module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [spq_pkg::PRI_W-1:0]       entry_priority,
	input  logic signed [spq_pkg::VAL_W-1:0] entry_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [spq_pkg::ST_W-1:0]        status,
	output logic signed [spq_pkg::VAL_W-1:0] removed_value,
	output logic [spq_pkg::PRI_W-1:0]       removed_priority,
	output logic [spq_pkg::OCC_W-1:0]       occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          out_valid_q;
	logic [spq_pkg::ST_W-1:0]  status_q;
	logic [spq_pkg::VAL_W-1:0] rval_q;
	logic [spq_pkg::PRI_W-1:0] rpri_q;
	logic [spq_pkg::OCC_W-1:0] occ_q;

	logic accept, full, empty, do_ins, do_rem;
	logic [spq_pkg::ST_W-1:0] status_d;

	spq_pkg::spq_ctrl_t ctrl;

	logic [DEPTH-1:0]          keep_a;
	logic [spq_pkg::PRI_W-1:0] pri_a [DEPTH];
	logic [spq_pkg::VAL_W-1:0] val_a [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_ins = accept && (opcode == spq_pkg::OP_INSERT) && !full;
	assign do_rem = accept && (opcode == spq_pkg::OP_REMOVE) && !empty;
	assign ctrl.insert = do_ins;
	assign ctrl.remove = do_rem;

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_rem) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		if (opcode == spq_pkg::OP_INSERT) begin
			status_d = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
		end else begin
			status_d = empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                      lk;
			logic [spq_pkg::PRI_W-1:0] lp, rp;
			logic [spq_pkg::VAL_W-1:0] lv, rv;
			if (gi == 0) begin : g_head
				assign lk = 1'b1;
				assign lp = entry_priority;
				assign lv = entry_value;
			end else begin : g_body
				assign lk = keep_a[gi-1];
				assign lp = pri_a[gi-1];
				assign lv = val_a[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign rp = pri_a[gi];
				assign rv = val_a[gi];
			end else begin : g_inner
				assign rp = pri_a[gi+1];
				assign rv = val_a[gi+1];
			end
			spq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (CW'(gi) < count_q),
				.new_pri   (entry_priority),
				.new_val   (entry_value),
				.left_keep (lk),
				.left_pri  (lp),
				.left_val  (lv),
				.right_pri (rp),
				.right_val (rv),
				.keep      (keep_a[gi]),
				.pri       (pri_a[gi]),
				.val       (val_a[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			rval_q <= do_rem ? val_a[0] : '0;
			rpri_q <= do_rem ? pri_a[0] : '0;
			occ_q <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign removed_value = rval_q;
	assign removed_priority = rpri_q;
	assign occupancy = occ_q;

endmodule

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, compares it with a new entry,
// and shifts toward the tail on insert or toward the front on remove. Uses spq_pkg.

module spq_cell (
	input  logic                          clk,
	input  spq_pkg::spq_ctrl_t            ctrl,
	input  logic                          occ,
	input  logic [spq_pkg::PRI_W-1:0]     new_pri,
	input  logic [spq_pkg::VAL_W-1:0]     new_val,
	input  logic                          left_keep,
	input  logic [spq_pkg::PRI_W-1:0]     left_pri,
	input  logic [spq_pkg::VAL_W-1:0]     left_val,
	input  logic [spq_pkg::PRI_W-1:0]     right_pri,
	input  logic [spq_pkg::VAL_W-1:0]     right_val,
	output logic                          keep,
	output logic [spq_pkg::PRI_W-1:0]     pri,
	output logic [spq_pkg::VAL_W-1:0]     val
);

	logic [spq_pkg::PRI_W-1:0] pri_q;
	logic [spq_pkg::VAL_W-1:0] val_q;

	// An occupied slot whose priority is not above the new one stays in place.
	assign keep = occ && (pri_q <= new_pri);
	assign pri = pri_q;
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				if (left_keep) begin
					pri_q <= new_pri;
					val_q <= new_val;
				end else begin
					pri_q <= left_pri;
					val_q <= left_val;
				end
			end
		end else if (ctrl.remove) begin
			pri_q <= right_pri;
			val_q <= right_val;
		end
	end

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sees only the ports of sorted_priority_queue.

module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [spq_pkg::ST_W-1:0]        status,
	input logic signed [spq_pkg::VAL_W-1:0] removed_value,
	input logic [spq_pkg::PRI_W-1:0]       removed_priority,
	input logic [spq_pkg::OCC_W-1:0]       occupancy
);

	localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(DEPTH);

	a_no_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == spq_pkg::ST_OK || status == spq_pkg::ST_UNDERFLOW ||
			status == spq_pkg::ST_OVERFLOW))
		else $error("invalid status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != spq_pkg::ST_OK) |->
			(removed_value == '0 && removed_priority == '0))
		else $error("error word carries removed data");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_UNDERFLOW) |-> (occupancy == '0))
		else $error("underflow with a nonempty queue");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::ST_OVERFLOW) |-> (occupancy == FULL_OCC))
		else $error("overflow with a queue that is not full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) &&
			$stable(removed_value) && $stable(removed_priority) && $stable(occupancy)))
		else $error("stalled output word changed");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.removed_value    (removed_value),
	.removed_priority (removed_priority),
	.occupancy        (occupancy)
);
